### design/spq_pkg.sv
`default_nettype none

package spq_pkg;

    // Queue geometry and field widths
    localparam int DEPTH        = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int PRIO_BITS    = 32;
    localparam int CNT_BITS     = $clog2(DEPTH + 1);

    // Stream packing: tdata is byte padded
    localparam int IN_FIELD_BITS  = PAYLOAD_BITS + PRIO_BITS;
    localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = 3 * PAYLOAD_BITS - PAYLOAD_BITS + PRIO_BITS
                                    + CNT_BITS + 1;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int KIND_BITS      = 2;
    localparam int STATUS_BITS    = 2;

    // Operation codes
    typedef enum logic [KIND_BITS-1:0] {
        KIND_ENQ = 2'd0,
        KIND_DEQ = 2'd1,
        KIND_CLR = 2'd2,
        KIND_NOP = 2'd3
    } kind_t;

    // Result status codes
    typedef enum logic [STATUS_BITS-1:0] {
        STAT_OK        = 2'd0,
        STAT_DEQ_EMPTY = 2'd1,
        STAT_ENQ_FULL  = 2'd2
    } status_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture the accepted item
        logic exec;   // apply the operation and load the result register
    } spq_cmd_t;

endpackage

`default_nettype wire

### design/spq_ctrl.sv
`default_nettype none

module spq_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output spq_pkg::spq_cmd_t     cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Handshake and commands
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign cmd.load = s_tvalid && s_tready;
    assign cmd.exec = (state_reg == ST_EXEC) && (!out_valid_reg || m_tready);

    // Next state
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (cmd.exec)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Checks
    a_load_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_EXEC))
        else $error("accepted item did not move to execute");

    a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> out_valid_reg)
        else $error("executed item produced no result");

    a_exec_not_over_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !cmd.exec)
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

### design/spq_dp.sv
`default_nettype none

module spq_dp (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire spq_pkg::spq_cmd_t                        cmd,
    input  wire spq_pkg::kind_t                           kind,
    input  wire logic        [spq_pkg::PAYLOAD_BITS-1:0]  payload,
    input  wire logic signed [spq_pkg::PRIO_BITS-1:0]     prio,
    output logic             [spq_pkg::PAYLOAD_BITS-1:0]  out_payload,
    output logic             [spq_pkg::PAYLOAD_BITS-1:0]  head_payload,
    output logic signed      [spq_pkg::PRIO_BITS-1:0]     head_prio,
    output logic             [spq_pkg::CNT_BITS-1:0]      occupancy,
    output logic                                          is_empty,
    output spq_pkg::status_t                              status
);

    localparam int DEPTH = spq_pkg::DEPTH;
    localparam int PB    = spq_pkg::PAYLOAD_BITS;
    localparam int RB    = spq_pkg::PRIO_BITS;
    localparam int CB    = spq_pkg::CNT_BITS;

    // Captured item
    spq_pkg::kind_t          kind_reg;
    logic        [PB-1:0]    pay_reg;
    logic signed [RB-1:0]    prio_reg;

    // Sorted entry array, slot 0 is the head
    logic        [PB-1:0]    slot_pay_reg  [DEPTH];
    logic signed [RB-1:0]    slot_prio_reg [DEPTH];
    logic        [PB-1:0]    slot_pay_next [DEPTH];
    logic signed [RB-1:0]    slot_prio_next[DEPTH];
    logic        [CB-1:0]    count_reg;
    logic        [CB-1:0]    count_next;

    // Result register
    logic        [PB-1:0]    out_pay_reg;
    logic        [PB-1:0]    head_pay_reg;
    logic signed [RB-1:0]    head_prio_reg;
    logic        [CB-1:0]    occ_reg;
    spq_pkg::status_t        status_reg;
    logic        [PB-1:0]    removed;
    spq_pkg::status_t        status_next;

    logic        [DEPTH-1:0] gt;
    logic        [DEPTH-1:0] gt_prev;
    logic                    full;
    logic                    empty;

    // Per slot compare: held entry orders strictly after the new one
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            gt[i] = (CB'(i) < count_reg) && (slot_prio_reg[i] > prio_reg);
        end
    end

    assign gt_prev = {gt[DEPTH-2:0], 1'b0};
    assign full    = (count_reg == CB'(DEPTH));
    assign empty   = (count_reg == '0);

    // Operation on the array
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_pay_next[i]  = slot_pay_reg[i];
            slot_prio_next[i] = slot_prio_reg[i];
        end
        count_next  = count_reg;
        removed     = '0;
        status_next = spq_pkg::STAT_OK;
        unique case (kind_reg)
            spq_pkg::KIND_ENQ:
            begin
                if (full)
                begin
                    status_next = spq_pkg::STAT_ENQ_FULL;
                end
                else
                begin
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (gt_prev[i])
                        begin
                            slot_pay_next[i]  = slot_pay_reg[(i + DEPTH - 1) % DEPTH];
                            slot_prio_next[i] = slot_prio_reg[(i + DEPTH - 1) % DEPTH];
                        end
                        else if (gt[i] || (CB'(i) == count_reg))
                        begin
                            slot_pay_next[i]  = pay_reg;
                            slot_prio_next[i] = prio_reg;
                        end
                    end
                    count_next = count_reg + 1'b1;
                end
            end
            spq_pkg::KIND_DEQ:
            begin
                if (empty)
                begin
                    status_next = spq_pkg::STAT_DEQ_EMPTY;
                end
                else
                begin
                    removed = slot_pay_reg[0];
                    for (int i = 0; i < DEPTH - 1; i++)
                    begin
                        slot_pay_next[i]  = slot_pay_reg[i + 1];
                        slot_prio_next[i] = slot_prio_reg[i + 1];
                    end
                    count_next = count_reg - 1'b1;
                end
            end
            spq_pkg::KIND_CLR:
            begin
                count_next = '0;
            end
            spq_pkg::KIND_NOP:
            begin
                count_next = count_reg;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // Item capture, array and result payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            pay_reg  <= payload;
            prio_reg <= prio;
        end
        if (cmd.exec)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                slot_pay_reg[i]  <= slot_pay_next[i];
                slot_prio_reg[i] <= slot_prio_next[i];
            end
            out_pay_reg   <= removed;
            head_pay_reg  <= (count_next != '0) ? slot_pay_next[0] : '0;
            head_prio_reg <= (count_next != '0) ? slot_prio_next[0] : '0;
            occ_reg       <= count_next;
            status_reg    <= status_next;
        end
    end

    // Entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    assign out_payload  = out_pay_reg;
    assign head_payload = head_pay_reg;
    assign head_prio    = head_prio_reg;
    assign occupancy    = occ_reg;
    assign is_empty     = (occ_reg == '0);
    assign status       = status_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CB'(DEPTH))
        else $error("entry count beyond depth");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && (kind_reg == spq_pkg::KIND_CLR)) |=> (count_reg == '0))
        else $error("clear left entries behind");

    a_full_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && (kind_reg == spq_pkg::KIND_ENQ) && full)
            |=> (count_reg == CB'(DEPTH)))
        else $error("enqueue on a full queue changed the count");

endmodule

`default_nettype wire

### design/sorted_priority_queue.sv
// Sorted priority queue, lowest priority first, ties in arrival order.
//
// Input stream (s_*): one item per operation. s_tuser carries the kind
// (enqueue, dequeue, clear, or the spare code as a no-op); s_tdata carries
// the payload tag and the signed Q16.16 priority used by an enqueue.
// Output stream (m_*): exactly one result item per input item, in order:
// removed payload, new head payload and priority, occupancy, empty flag
// in m_tdata and the status code in m_tuser.
//
// A result is registered in the execute state, after its item is captured,
// provided the result register is free by then.
// The queue handles one item at a time, a capture cycle followed by an
// execute cycle in which all sixteen slots compare against the new priority
// and shift in parallel.
// The result register lets the next item be accepted while a result waits.
// If the receiver stalls, the result holds and the next item waits in the
// execute cycle; the input side then stalls too.
// Reset empties the queue and drops any pending result; slot contents are
// left as they are and are never visible until written.
`default_nettype none

module sorted_priority_queue (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // payload, prio
    input  wire logic [spq_pkg::IN_TDATA_BITS-1:0]   s_tdata,
    // kind
    input  wire logic [spq_pkg::KIND_BITS-1:0]       s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // out_payload, head_payload, head_prio, occupancy, is_empty, zero pad
    output logic      [spq_pkg::OUT_TDATA_BITS-1:0]  m_tdata,
    // status
    output logic      [spq_pkg::STATUS_BITS-1:0]     m_tuser
);

    localparam int PB = spq_pkg::PAYLOAD_BITS;
    localparam int RB = spq_pkg::PRIO_BITS;

    spq_pkg::spq_cmd_t                 cmd;
    logic        [PB-1:0]              out_payload;
    logic        [PB-1:0]              head_payload;
    logic signed [RB-1:0]              head_prio;
    logic        [spq_pkg::CNT_BITS-1:0] occupancy;
    logic                              is_empty;
    spq_pkg::status_t                  status;

    // Controller
    spq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Datapath
    spq_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .kind         (spq_pkg::kind_t'(s_tuser)),
        .payload      (s_tdata[PB-1:0]),
        .prio         ($signed(s_tdata[PB +: RB])),
        .out_payload  (out_payload),
        .head_payload (head_payload),
        .head_prio    (head_prio),
        .occupancy    (occupancy),
        .is_empty     (is_empty),
        .status       (status)
    );

    // Result packing
    assign m_tdata = spq_pkg::OUT_TDATA_BITS'({is_empty, occupancy, head_prio,
                                               head_payload, out_payload});
    assign m_tuser = status;

endmodule

`default_nettype wire
